// ===== hw/rtl/bls_pkg.sv =====
package bls_pkg;

   // One charge-percent sample, 0..100
   typedef logic [6:0] sample_type;

   // Sorted position of one sample among the lanes
   typedef logic [2:0] rank_type;

   // Level register: plain percent (gauge mode) or ten times percent (sampled mode)
   typedef logic [9:0] level_type;

   // Most lanes the request carries samples for
   localparam int MAX_LANES = 5;

   localparam sample_type PCT_MAX = 7'd100;

   // Configuration register indexes
   typedef enum logic {
      REG_USE_FUEL_GAUGE = 1'b0,
      REG_POLL_INTERVAL  = 1'b1
   } csr_reg_type;

   // Saturate one raw sample at 100 percent
   function automatic sample_type sat_sample(input sample_type v);
      return (v > PCT_MAX) ? PCT_MAX : v;
   endfunction

endpackage

// ===== hw/rtl/bls_rank_lane.sv =====
// One lane: counts how many samples sort ahead of its own sample.
// Equal samples are ordered by lane index, so the ranks are unique.
module bls_rank_lane #(
   parameter int LANE_COUNT = 5,
   parameter int LANE_IDX   = 0
) (
   input  bls_pkg::sample_type samples [LANE_COUNT],
   output bls_pkg::rank_type   rank
);

   always_comb begin
      rank = '0;
      for (int j = 0; j < LANE_COUNT; j++) begin
         if (j != LANE_IDX) begin
            if ((samples[j] < samples[LANE_IDX]) ||
                ((samples[j] == samples[LANE_IDX]) && (j < LANE_IDX))) begin
               rank = rank + bls_pkg::rank_type'(1);
            end
         end
      end
   end

endmodule

// ===== hw/rtl/bls_median.sv =====
// Median of the first LANE_COUNT samples: one rank lane per sample,
// then a merge that picks the sample whose rank is the middle one.
module bls_median #(
   parameter int LANE_COUNT = 5
) (
   input  bls_pkg::sample_type samples_raw [bls_pkg::MAX_LANES],
   output bls_pkg::sample_type median
);

   localparam bls_pkg::rank_type MID_RANK = bls_pkg::rank_type'(LANE_COUNT / 2);

   bls_pkg::sample_type sat_s [LANE_COUNT];
   bls_pkg::rank_type   ranks [LANE_COUNT];

   // Saturate inputs and rank them in parallel
   for (genvar g = 0; g < LANE_COUNT; g++) begin : g_lane
      assign sat_s[g] = bls_pkg::sat_sample(samples_raw[g]);

      bls_rank_lane #(
         .LANE_COUNT (LANE_COUNT),
         .LANE_IDX   (g)
      ) u_lane (
         .samples (sat_s),
         .rank    (ranks[g])
      );
   end

   // Merge: exactly one lane holds the middle rank
   always_comb begin
      median = '0;
      for (int k = 0; k < LANE_COUNT; k++) begin
         if (ranks[k] == MID_RANK) begin
            median = median | sat_s[k];
         end
      end
   end

endmodule

// ===== hw/rtl/battery_level_median_ema_filter.sv =====
// Battery level filter: throttled polling, median of samples, smoothed level.
// A result is registered in stage A, then in stage B. Throughput: one request
// per cycle unless the result stream stalls; the poll-time and level
// registers are updated in the accept cycle (compare network plus constant
// divide by ten). Reset (synchronous): mode = sampled, poll interval = 1000 ms,
// level = 0, last poll time = 0 (never polled), pipeline empty.
module battery_level_median_ema_filter #(
   parameter int SAMPLE_COUNT = 5
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: now_ms[31:0], sample_a..sample_e[66:32], gauge_soc[82:67], zero fill
   input  logic [87:0] req_tdata,
   // tuser: gauge_ok
   input  logic        req_tuser,
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: percent[6:0], zero fill
   output logic [7:0]  rsp_tdata,
   // tuser: fresh
   output logic        rsp_tuser,
   // configuration writes
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [23:0] csr_wdata
);

   localparam int LANE_COUNT = (SAMPLE_COUNT > bls_pkg::MAX_LANES) ? bls_pkg::MAX_LANES :
                               ((SAMPLE_COUNT < 1) ? 1 : SAMPLE_COUNT);

   // floor(x/10) for x below 2^14, by reciprocal multiply
   function automatic logic [10:0] div10(input logic [13:0] x);
      logic [27:0] prod;
      prod = x * 14'd13108;
      return prod[27:17];
   endfunction

   // Configuration and state
   logic                use_fg_ff,        use_fg_in;
   logic [23:0]         poll_interval_ff, poll_interval_in;
   logic [31:0]         last_poll_ff,     last_poll_in;
   bls_pkg::level_type  level_ff,         level_in;

   // Stage A: updated level per transaction
   logic                a_valid_ff,  a_valid_in;
   bls_pkg::level_type  a_level_ff,  a_level_in;
   logic                a_fg_ff,     a_fg_in;
   logic                a_fresh_ff,  a_fresh_in;

   // Stage B: output register
   logic                b_valid_ff,  b_valid_in;
   bls_pkg::sample_type b_pct_ff,    b_pct_in;
   logic                b_fresh_ff,  b_fresh_in;

   logic                accept;
   logic                b_free;
   logic [31:0]         now_ms;
   logic [15:0]         gauge_soc;
   logic [31:0]         elapsed;
   logic                throttled;
   bls_pkg::sample_type samples_raw [bls_pkg::MAX_LANES];
   bls_pkg::sample_type median;
   logic [13:0]         nine_level;
   logic [10:0]         nine_div;
   logic [10:0]         a_div;

   // Request field unpacking
   assign now_ms    = req_tdata[31:0];
   assign gauge_soc = req_tdata[82:67];
   for (genvar g = 0; g < bls_pkg::MAX_LANES; g++) begin : g_unpack
      assign samples_raw[g] = req_tdata[32 + 7*g +: 7];
   end

   bls_median #(
      .LANE_COUNT (LANE_COUNT)
   ) u_median (
      .samples_raw (samples_raw),
      .median      (median)
   );

   // Handshake: stage A empties into B whenever B is free
   assign b_free     = !b_valid_ff || rsp_tready;
   assign req_tready = !a_valid_ff || b_free;
   assign accept     = req_tvalid && req_tready;

   // Poll throttle
   assign elapsed   = now_ms - last_poll_ff;
   assign throttled = (last_poll_ff != 32'd0) && (elapsed < {8'd0, poll_interval_ff});

   // Smoothing: floor((9L + 10m)/10) = floor(9L/10) + m
   assign nine_level = {1'b0, level_ff, 3'b000} + {4'd0, level_ff};
   assign nine_div   = div10(nine_level);

   // Configuration writes
   always_comb begin
      use_fg_in        = use_fg_ff;
      poll_interval_in = poll_interval_ff;
      if (csr_we) begin
         unique case (bls_pkg::csr_reg_type'(csr_addr))
            bls_pkg::REG_USE_FUEL_GAUGE: use_fg_in        = csr_wdata[0];
            bls_pkg::REG_POLL_INTERVAL:  poll_interval_in = csr_wdata;
            default:                     use_fg_in        = use_fg_ff;
         endcase
      end
   end

   // State update on each accepted transaction that polls
   always_comb begin
      last_poll_in = last_poll_ff;
      level_in     = level_ff;
      if (accept && !throttled) begin
         last_poll_in = now_ms;
         if (use_fg_ff) begin
            if (req_tuser) begin
               level_in = (gauge_soc > 16'd100) ? 10'd100 : gauge_soc[9:0];
            end
         end else if (level_ff == 10'd0) begin
            level_in = {median, 3'b000} + {2'b00, median, 1'b0};
         end else begin
            level_in = nine_div[9:0] + {3'b000, median};
         end
      end
   end

   // Stage A load
   always_comb begin
      a_valid_in = a_valid_ff;
      a_level_in = a_level_ff;
      a_fg_in    = a_fg_ff;
      a_fresh_in = a_fresh_ff;
      if (accept) begin
         a_valid_in = 1'b1;
         a_level_in = level_in;
         a_fg_in    = use_fg_ff;
         a_fresh_in = !throttled;
      end else if (b_free) begin
         a_valid_in = 1'b0;
      end
   end

   // Stage B: scale level to percent
   assign a_div = div10({4'd0, a_level_ff});

   always_comb begin
      b_valid_in = b_valid_ff;
      b_pct_in   = b_pct_ff;
      b_fresh_in = b_fresh_ff;
      if (b_free) begin
         b_valid_in = a_valid_ff;
         b_fresh_in = a_fresh_ff;
         if (a_fg_ff) begin
            b_pct_in = (a_level_ff > 10'd100) ? bls_pkg::PCT_MAX : a_level_ff[6:0];
         end else begin
            b_pct_in = (a_div > 11'd100) ? bls_pkg::PCT_MAX : a_div[6:0];
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         use_fg_ff        <= 1'b0;
         poll_interval_ff <= 24'd1000;
         last_poll_ff     <= '0;
         level_ff         <= '0;
         a_valid_ff       <= 1'b0;
         b_valid_ff       <= 1'b0;
      end else begin
         use_fg_ff        <= use_fg_in;
         poll_interval_ff <= poll_interval_in;
         last_poll_ff     <= last_poll_in;
         level_ff         <= level_in;
         a_valid_ff       <= a_valid_in;
         b_valid_ff       <= b_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      a_level_ff <= a_level_in;
      a_fg_ff    <= a_fg_in;
      a_fresh_ff <= a_fresh_in;
      b_pct_ff   <= b_pct_in;
      b_fresh_ff <= b_fresh_in;
   end

   assign rsp_tvalid = b_valid_ff;
   assign rsp_tdata  = {1'b0, b_pct_ff};
   assign rsp_tuser  = b_fresh_ff;

   // Level stays within the smoothing range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      level_ff <= 10'd1020)
      else $error("level register out of range");

   // A throttled request leaves the level alone
   a_throttle_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && throttled) |=> $stable(level_ff) && $stable(last_poll_ff))
      else $error("throttled request changed state");

   // A polling request records its timestamp
   a_poll_time: assert property (@(posedge clock) disable iff (reset)
      (accept && !throttled) |=> (last_poll_ff == $past(now_ms)))
      else $error("poll time not recorded");

   // Stage A holds its transaction while stage B is blocked
   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !b_free) |=> (a_valid_ff && $stable(a_level_ff)))
      else $error("stage A lost a transaction");

endmodule
